// ===== design/css_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// css_pkg
// Shared types and constants of the conveyor sort sequencer.
// ----------------------------------------------------------------------------
package css_pkg;

   localparam int DIF_W   = 7;
   localparam int BEAM_W  = 2;
   localparam int LIM_W   = 3;
   localparam int STATE_W = 4;
   localparam int KIND_W  = 2;
   localparam int ACT_W   = 7;

   // actuator register bit positions
   localparam int ACT_EMIT = 0;
   localparam int ACT_G1   = 1;
   localparam int ACT_G2   = 2;
   localparam int ACT_PUSH = 3;
   localparam int ACT_WARN = 6;

   localparam logic [ACT_W-1:0] ACT_RESET_OUTPUTS = 7'b000_0110;
   localparam logic [ACT_W-1:0] ACT_PUSH_MASK     = 7'b011_1000;

   // classification codes: {diffuse bit 2, diffuse bit 1, gate beam broken}
   localparam logic [2:0] CLS_CODE_TYPE1 = 3'd7;
   localparam logic [2:0] CLS_CODE_TYPE2 = 3'd6;
   localparam logic [2:0] CLS_CODE_TYPE3 = 3'd4;

   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TYPE1   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TYPE2   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TYPE3   = 2'd3;

   typedef enum logic [STATE_W-1:0] {
      ST_NOT_READY  = 4'd0,
      ST_READY      = 4'd1,
      ST_WAIT_G1    = 4'd2,
      ST_AT_G1      = 4'd3,
      ST_DETECTED   = 4'd4,
      ST_WAIT_G2    = 4'd5,
      ST_WEIGHING   = 4'd6,
      ST_WEIGHED    = 4'd7,
      ST_PRE_PUSH   = 4'd8,
      ST_AT_PUSHER  = 4'd9,
      ST_PUSHING    = 4'd10,
      ST_PUSHED     = 4'd11,
      ST_WAIT_CHUTE = 4'd12,
      ST_SORTED     = 4'd13,
      ST_ERROR      = 4'd14
   } seq_state_type;

   typedef struct packed {
      logic [DIF_W-1:0]  diffuse_sensors;
      logic [BEAM_W-1:0] beam_sensors;
      logic [LIM_W-1:0]  push_limits;
      logic              reset_button;
   } scan_type;

   // held request between the input stage and the core
   typedef struct packed {
      logic     valid;
      scan_type scan;
   } stage_type;

endpackage

`default_nettype wire

// ===== design/css_channels.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// css channels
// Valid/ready channel interfaces for requests, results and the control
// register write port.
// ----------------------------------------------------------------------------
interface css_req_if import css_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIF_W-1:0]  diffuse_sensors;
   logic [BEAM_W-1:0] beam_sensors;
   logic [LIM_W-1:0]  push_limits;
   logic              reset_button;

   modport source (output valid, diffuse_sensors, beam_sensors, push_limits, reset_button,
                   input ready);
   modport sink   (input valid, diffuse_sensors, beam_sensors, push_limits, reset_button,
                   output ready);
endinterface

interface css_rsp_if import css_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               emitter_on;
   logic               gate_one_raised;
   logic               gate_two_raised;
   logic [LIM_W-1:0]   pusher_extend;
   logic               warning_light;
   logic [STATE_W-1:0] sequence_state;
   logic [KIND_W-1:0]  box_class;

   modport source (output valid, emitter_on, gate_one_raised, gate_two_raised,
                   pusher_extend, warning_light, sequence_state, box_class,
                   input ready);
   modport sink   (input valid, emitter_on, gate_one_raised, gate_two_raised,
                   pusher_extend, warning_light, sequence_state, box_class,
                   output ready);
endinterface

interface css_csr_if ();
   logic valid;
   logic ready;
   logic start_with_reset;

   modport source (output valid, start_with_reset, input ready);
   modport sink   (input valid, start_with_reset, output ready);
endinterface

`default_nettype wire

// ===== design/conveyor_sort_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conveyor_sort_sequencer
// Box sorting sequencer for a conveyor: one sequence step per scan request.
// ----------------------------------------------------------------------------
// Each request is one scan of the conveyor sensors and produces exactly one
// result: the actuator levels, sequence state and box class after the step.
// A request is registered in the input stage, and the step is then taken into
// the result register once it is free; one request is accepted every cycle
// as long as results are taken. The control register start_with_reset (reset
// value 1) picks the start state and acts only until the first request after
// reset; the user must write it only while idle, which the block does not enforce.
module conveyor_sort_sequencer import css_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   css_req_if.sink   req_chan,
   css_rsp_if.source rsp_chan,
   css_csr_if.sink   csr_chan
);

   stage_type stage;
   logic      take;

   css_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .stage    (stage)
   );

   css_core u_core (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage),
      .take     (take),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

`ifndef ASSERT_OFF
   // warning lamp only ever lit while in the error state
   a_warn_in_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.warning_light) |->
         (rsp_chan.sequence_state == ST_ERROR))
      else $error("warning light outside error state");

   // sorting states always carry a known box class
   a_class_known: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.sequence_state >= ST_DETECTED &&
       rsp_chan.sequence_state <= ST_SORTED) |-> (rsp_chan.box_class != KIND_UNKNOWN))
      else $error("sorting without box class");

   // a request with the end chute occupied always lands in error
   a_chute_error: assert property (@(posedge clock) disable iff (reset)
      (take && stage.scan.diffuse_sensors[0]) |=>
         (rsp_chan.valid && rsp_chan.sequence_state == ST_ERROR))
      else $error("end chute box did not force error");
`endif

endmodule

`default_nettype wire

// ===== design/css_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// css_in_stage
// Input register: captures one request and holds it until the core takes it.
// ----------------------------------------------------------------------------
module css_in_stage import css_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   css_req_if.sink    req_chan,
   input  wire logic  take,
   output stage_type  stage
);

   logic     valid_ff;
   logic     valid_in;
   scan_type scan_ff;
   logic     accept;

   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         scan_ff.diffuse_sensors <= req_chan.diffuse_sensors;
         scan_ff.beam_sensors    <= req_chan.beam_sensors;
         scan_ff.push_limits     <= req_chan.push_limits;
         scan_ff.reset_button    <= req_chan.reset_button;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.scan  = scan_ff;

endmodule

`default_nettype wire

// ===== design/css_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// css_core
// Sequence state, box class and actuator registers, the one-step transition
// logic and the result register.
// ----------------------------------------------------------------------------
module css_core import css_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  stage_type  stage,
   output logic       take,
   css_rsp_if.source  rsp_chan,
   css_csr_if.sink    csr_chan
);

   seq_state_type     state_ff, state_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic              untouched_ff;
   logic              rsp_valid_ff;
   logic              csr_write;
   logic [2:0]        cls_code;
   logic [LIM_W-1:0]  push_sel;
   logic              at_pusher;
   logic              push_done;
   logic [DIF_W-1:0]  dif;

   assign dif       = stage.scan.diffuse_sensors;
   assign take      = stage.valid && (!rsp_valid_ff || rsp_chan.ready);
   assign csr_write = csr_chan.valid && csr_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign cls_code = {dif[2], dif[1], ~stage.scan.beam_sensors[0]};

   // one-hot pusher of the current box type, and its sensors
   always_comb begin
      case (kind_ff)
         KIND_TYPE1: begin
            push_sel = 3'b001;
         end
         KIND_TYPE2: begin
            push_sel = 3'b010;
         end
         KIND_TYPE3: begin
            push_sel = 3'b100;
         end
         default: begin
            push_sel = 3'b000;
         end
      endcase
   end

   assign at_pusher = |(push_sel & dif[DIF_W-1:DIF_W-LIM_W]);
   assign push_done = |(push_sel & stage.scan.push_limits);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      act_in   = act_ff;
      case (state_ff)
         ST_NOT_READY: begin
            act_in   = ACT_RESET_OUTPUTS;
            state_in = ST_READY;
         end
         ST_READY: begin
            act_in[ACT_EMIT] = 1'b1;
            state_in         = ST_WAIT_G1;
         end
         ST_WAIT_G1: begin
            if (dif[2]) begin
               act_in[ACT_EMIT] = 1'b0;
               state_in         = ST_AT_G1;
            end
         end
         ST_AT_G1: begin
            case (cls_code)
               CLS_CODE_TYPE1: begin
                  kind_in = KIND_TYPE1;
               end
               CLS_CODE_TYPE2: begin
                  kind_in = KIND_TYPE2;
               end
               CLS_CODE_TYPE3: begin
                  kind_in = KIND_TYPE3;
               end
               default: begin
                  kind_in = KIND_UNKNOWN;
               end
            endcase
            state_in = (kind_in != KIND_UNKNOWN) ? ST_DETECTED : ST_ERROR;
         end
         ST_DETECTED: begin
            act_in[ACT_G1] = 1'b0;
            act_in[ACT_G2] = 1'b1;
            state_in       = ST_WAIT_G2;
         end
         ST_WAIT_G2: begin
            if (dif[3]) begin
               state_in = ST_WEIGHING;
            end
         end
         ST_WEIGHING: begin
            state_in = ST_WEIGHED;
         end
         ST_WEIGHED: begin
            act_in[ACT_G2] = 1'b0;
            state_in       = ST_PRE_PUSH;
         end
         ST_PRE_PUSH: begin
            if (at_pusher) begin
               state_in = ST_AT_PUSHER;
            end
         end
         ST_AT_PUSHER: begin
            act_in[ACT_PUSH +: LIM_W] = act_ff[ACT_PUSH +: LIM_W] | push_sel;
            state_in                  = ST_PUSHING;
         end
         ST_PUSHING: begin
            if (push_done) begin
               state_in = ST_PUSHED;
            end
         end
         ST_PUSHED: begin
            state_in = ST_WAIT_CHUTE;
         end
         ST_WAIT_CHUTE: begin
            // chute beam is broken when low
            if (!stage.scan.beam_sensors[1]) begin
               act_in   = act_ff & ~ACT_PUSH_MASK;
               state_in = ST_SORTED;
            end
         end
         ST_SORTED: begin
            act_in   = ACT_RESET_OUTPUTS;
            state_in = ST_READY;
         end
         ST_ERROR: begin
            act_in[ACT_WARN] = 1'b1;
            act_in[ACT_EMIT] = 1'b0;
            if (stage.scan.reset_button) begin
               act_in   = ACT_RESET_OUTPUTS;
               state_in = ST_READY;
            end
         end
         default: begin
         end
      endcase
      // box in the end chute overrides the next state
      if (dif[0]) begin
         state_in = ST_ERROR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_NOT_READY;
         kind_ff      <= KIND_UNKNOWN;
         act_ff       <= '0;
         untouched_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            state_ff     <= state_in;
            kind_ff      <= kind_in;
            act_ff       <= act_in;
            untouched_ff <= 1'b0;
         end else if (csr_write && untouched_ff) begin
            // start state follows the register until the first request
            state_ff <= csr_chan.start_with_reset ? ST_NOT_READY : ST_READY;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.emitter_on      = act_ff[ACT_EMIT];
   assign rsp_chan.gate_one_raised = act_ff[ACT_G1];
   assign rsp_chan.gate_two_raised = act_ff[ACT_G2];
   assign rsp_chan.pusher_extend   = act_ff[ACT_PUSH +: LIM_W];
   assign rsp_chan.warning_light   = act_ff[ACT_WARN];
   assign rsp_chan.sequence_state  = state_ff;
   assign rsp_chan.box_class       = kind_ff;

endmodule

`default_nettype wire
